@@ design/k_smallest_selector_macros.svh @@
// Assertion macros shared by the selector RTL files.
`ifndef K_SMALLEST_SELECTOR_MACROS_SVH
`define K_SMALLEST_SELECTOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clk outside reset.
`define KSS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising clk outside reset.
`define KSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KSS_ASSERT_IMPL(lbl, ante, cons, msg)
`define KSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/kss_pkg.sv @@
// Shared types and constants of the k-smallest selector.
`timescale 1ns / 1ps
package kss_pkg;

    localparam int KEY_W   = 32;
    localparam int ID_W    = 32;
    localparam int ENTRY_W = KEY_W + ID_W;

    // Request codes carried on req_type.
    typedef enum logic {
        REQ_INSERT  = 1'b0,
        REQ_READOUT = 1'b1
    } req_t;

    // One held entry as it sits in the store.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
    } entry_t;

    // Flags from the shared key comparator.
    typedef struct packed {
        logic le;
        logic eq;
    } cmp_res_t;

endpackage

@@ design/k_smallest_selector.sv @@
// Top level of the k-smallest selector: sequencer, sorted store and result registers.
//
//  channel   | ports                                   | transfer
//  ----------+-----------------------------------------+---------------------------------
//  request   | start, busy, req_type, key, cand_id     | start high while busy low
//  result    | result_strobe, accepted, entry_valid,   | every cycle result_strobe is high
//            | out_key, out_id, last                   |
//  config    | cfg_we, cfg_wdata                       | every cycle cfg_we is high
//
// An insert into an empty store, and a readout of an empty store, finish at once and
// busy stays low. Any other insert walks the sorted store through the one RAM port
// pair and the shared comparator, one entry a cycle. A readout streams its entries
// with busy high, one entry a cycle from the registered RAM read. Reset clears the
// entry count and the mode; the store itself is never cleared, since only counted
// entries are read. The receiver cannot stall: each result shows for exactly one
// cycle.
`timescale 1ns / 1ps
`include "k_smallest_selector_macros.svh"
module k_smallest_selector #(
    parameter int K = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    input  logic                             start,
    output logic                             busy,
    input  logic                             req_type,
    input  logic signed [kss_pkg::KEY_W-1:0] key,
    input  logic [kss_pkg::ID_W-1:0]         cand_id,
    output logic                             result_strobe,
    output logic                             accepted,
    output logic                             entry_valid,
    output logic signed [kss_pkg::KEY_W-1:0] out_key,
    output logic [kss_pkg::ID_W-1:0]         out_id,
    output logic                             last
);
    import kss_pkg::*;

    localparam int IW    = (K > 1) ? $clog2(K) : 1;
    localparam int CNT_W = $clog2(K + 1);
    localparam logic [IW-1:0]    IDX_LAST = IW'(K - 1);
    localparam logic [IW-1:0]    IDX_PREV = IW'((K > 1) ? K - 2 : 0);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(K);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DOWN,
        ST_UP_GROUP,
        ST_UP_SHIFT,
        ST_PLACE,
        ST_READ
    } state_t;

    state_t                  state_reg, state_next;
    logic [IW-1:0]           cur_reg, cur_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    sel_reg, sel_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic signed [KEY_W-1:0] key0_reg, key0_next;
    logic                    strobe_reg, strobe_next;
    logic                    accepted_reg, accepted_next;
    logic                    entry_valid_reg, entry_valid_next;
    logic signed [KEY_W-1:0] out_key_reg, out_key_next;
    logic [ID_W-1:0]         out_id_reg, out_id_next;
    logic                    last_reg, last_next;

    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    entry_t                  wr_data;
    logic [IW-1:0]           rd_addr;
    logic [ENTRY_W-1:0]      ram_rdata;
    entry_t                  rd_entry;
    logic signed [KEY_W-1:0] cmp_b;
    cmp_res_t                cmp;
    logic                    full;
    logic [IW-1:0]           count_m1;
    logic [IW-1:0]           cur_inc;
    logic [IW-1:0]           cur_dec;
    logic                    fin;
    logic                    fin_acc;

    // Sorted store: ascending keys, equal keys oldest first.
    kss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (K)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // The group walk compares against the smallest held key, every other step
    // against the new key.
    assign cmp_b = (state_reg == ST_UP_GROUP) ? key0_reg : key_reg;

    kss_cmp u_cmp (
        .a   (rd_entry.key),
        .b   (cmp_b),
        .res (cmp)
    );

    assign full     = (count_reg == CNT_FULL);
    assign count_m1 = IW'(count_reg - CNT_W'(1));
    assign cur_inc  = cur_reg + IW'(1);
    assign cur_dec  = cur_reg - IW'(1);

    // Sequencer: next state, store accesses and result values.
    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        count_next       = count_reg;
        sel_next         = cfg_we ? cfg_wdata : sel_reg;
        key_next         = key_reg;
        id_next          = id_reg;
        key0_next        = key0_reg;
        strobe_next      = 1'b0;
        accepted_next    = 1'b0;
        entry_valid_next = 1'b0;
        out_key_next     = '0;
        out_id_next      = '0;
        last_next        = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = cur_reg;
        wr_data          = '{key: key_reg, id: id_reg};
        rd_addr          = cur_reg;
        fin              = 1'b0;
        fin_acc          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next = key;
                    id_next  = cand_id;
                    if (req_type == REQ_READOUT)
                    begin
                        if (count_reg == '0)
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            rd_addr    = '0;
                            cur_next   = '0;
                            state_next = ST_READ;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = '{key: key, id: cand_id};
                        fin     = 1'b1;
                        fin_acc = 1'b1;
                    end
                    else if (!full)
                    begin
                        rd_addr    = count_m1;
                        cur_next   = count_m1;
                        state_next = ST_DOWN;
                    end
                    else
                    begin
                        rd_addr    = sel_reg ? '0 : IDX_LAST;
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (!sel_reg)
                begin
                    // Keeping the smallest: the worst entry is the last one.
                    if (!cmp.le)
                    begin
                        if (K == 1)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            fin     = 1'b1;
                            fin_acc = 1'b1;
                        end
                        else
                        begin
                            rd_addr    = IDX_PREV;
                            cur_next   = IDX_PREV;
                            state_next = ST_DOWN;
                        end
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                else
                begin
                    // Keeping the largest: the worst is the newest of the smallest keys.
                    key0_next = rd_entry.key;
                    if (cmp.le && !cmp.eq)
                    begin
                        if (K == 1)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            fin     = 1'b1;
                            fin_acc = 1'b1;
                        end
                        else
                        begin
                            rd_addr    = IW'(1);
                            cur_next   = IW'(1);
                            state_next = ST_UP_GROUP;
                        end
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end

            ST_DOWN:
            begin
                // Move larger entries up one place until the new key's slot is found.
                if (!cmp.le)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cur_inc;
                    wr_data = rd_entry;
                    if (cur_reg == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        cur_next = cur_dec;
                        rd_addr  = cur_dec;
                    end
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = cur_inc;
                    fin     = 1'b1;
                    fin_acc = 1'b1;
                end
            end

            ST_UP_GROUP:
            begin
                // Skip the group equal to the smallest key; its last member is evicted.
                if (cmp.le)
                begin
                    if (cur_reg == IDX_LAST)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        cur_next = cur_inc;
                        rd_addr  = cur_inc;
                    end
                end
                else
                begin
                    rd_addr    = cur_reg;
                    state_next = ST_UP_SHIFT;
                end
            end

            ST_UP_SHIFT:
            begin
                // Move entries not above the new key down one place over the evicted slot.
                wr_en   = 1'b1;
                wr_addr = cur_dec;
                if (cmp.le)
                begin
                    wr_data = rd_entry;
                    if (cur_reg == IDX_LAST)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        cur_next = cur_inc;
                        rd_addr  = cur_inc;
                    end
                end
                else
                begin
                    fin     = 1'b1;
                    fin_acc = 1'b1;
                end
            end

            ST_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                fin     = 1'b1;
                fin_acc = 1'b1;
            end

            ST_READ:
            begin
                // One held entry per cycle in store order.
                strobe_next      = 1'b1;
                entry_valid_next = 1'b1;
                out_key_next     = rd_entry.key;
                out_id_next      = rd_entry.id;
                if (cur_reg == count_m1)
                begin
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_inc;
                    rd_addr  = cur_inc;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Close an insert with its single result.
        if (fin)
        begin
            strobe_next   = 1'b1;
            last_next     = 1'b1;
            accepted_next = fin_acc;
            state_next    = ST_IDLE;
            if (fin_acc && !full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // State, counters and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_reg         <= '0;
            count_reg       <= '0;
            sel_reg         <= 1'b0;
            key_reg         <= '0;
            id_reg          <= '0;
            key0_reg        <= '0;
            strobe_reg      <= 1'b0;
            accepted_reg    <= 1'b0;
            entry_valid_reg <= 1'b0;
            out_key_reg     <= '0;
            out_id_reg      <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            count_reg       <= count_next;
            sel_reg         <= sel_next;
            key_reg         <= key_next;
            id_reg          <= id_next;
            key0_reg        <= key0_next;
            strobe_reg      <= strobe_next;
            accepted_reg    <= accepted_next;
            entry_valid_reg <= entry_valid_next;
            out_key_reg     <= out_key_next;
            out_id_reg      <= out_id_next;
            last_reg        <= last_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = strobe_reg;
    assign accepted      = accepted_reg;
    assign entry_valid   = entry_valid_reg;
    assign out_key       = out_key_reg;
    assign out_id        = out_id_reg;
    assign last          = last_reg;

    // The entry count never passes the store depth.
    `KSS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_FULL, "entry count above K")
    // An insert result is always the only and last result of its request.
    `KSS_ASSERT_IMPL(a_insert_last, strobe_reg && !entry_valid_reg, last_reg,
        "insert result without last")
    // A kept candidate leaves a non-empty store.
    `KSS_ASSERT_IMPL(a_kept_nonempty, strobe_reg && accepted_reg, count_reg != '0,
        "candidate kept but store empty")
    // Readout entries come out in ascending key order, back to back.
    `KSS_ASSERT_NEXT(a_read_sorted, strobe_reg && entry_valid_reg && !last_reg,
        strobe_reg && entry_valid_reg && (out_key_reg >= $past(out_key_reg)),
        "readout not ascending or not contiguous")

endmodule

@@ design/kss_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module kss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ design/kss_cmp.sv @@
// Shared signed key comparator used by every step of the store walk.
`timescale 1ns / 1ps
module kss_cmp (
    input  logic signed [kss_pkg::KEY_W-1:0] a,
    input  logic signed [kss_pkg::KEY_W-1:0] b,
    output kss_pkg::cmp_res_t                res
);
    import kss_pkg::*;

    // Two signed compares give the le and eq flags.
    always_comb
    begin
        res.le = (a <= b);
        res.eq = (a == b);
    end

endmodule

@@ tb/k_smallest_selector_checker.sv @@
// Checker for the k-smallest selector: tracks the store, predicts results and compares them.
`timescale 1ns / 1ps
module k_smallest_selector_checker #(
    parameter int K = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             req_type,
    input  logic signed [kss_pkg::KEY_W-1:0] key,
    input  logic [kss_pkg::ID_W-1:0]         cand_id,
    input  logic                             result_strobe,
    input  logic                             accepted,
    input  logic                             entry_valid,
    input  logic signed [kss_pkg::KEY_W-1:0] out_key,
    input  logic [kss_pkg::ID_W-1:0]         out_id,
    input  logic                             last,
    output int                               fail_count,
    output int                               pending,
    output int                               results_seen,
    output int                               inserts_kept,
    output int                               inserts_dropped,
    output int                               readouts_seen
);
    import kss_pkg::*;

    // One result as the block should present it.
    typedef struct packed {
        logic                    kept;
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
        logic                    last;
    } sel_result_t;

    // Shadow copy of the sorted store and the mode register.
    logic signed [KEY_W-1:0] store_key [K];
    logic [ID_W-1:0]         store_id [K];
    int                      store_count;
    logic                    keep_largest;

    sel_result_t expected_q[$];

    int mismatches = 0;
    int n_results  = 0;
    int n_kept     = 0;
    int n_dropped  = 0;
    int n_readouts = 0;

    assign fail_count      = mismatches;
    assign results_seen    = n_results;
    assign inserts_kept    = n_kept;
    assign inserts_dropped = n_dropped;
    assign readouts_seen   = n_readouts;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Append one expected result at the tail of the queue.
    task automatic queue_expected(input sel_result_t r);
        expected_q.insert(expected_q.size(), r);
    endtask

    // Remove the entry at idx and close the gap.
    function automatic void drop_entry(input int idx);
        int i;
        for (i = idx; i + 1 < store_count; i++) begin
            store_key[i] = store_key[i + 1];
            store_id[i]  = store_id[i + 1];
        end
        store_count--;
    endfunction

    // Insert after every entry with a key not above the new one, so ties stay oldest first.
    function automatic void place_entry(input logic signed [KEY_W-1:0] k,
                                        input logic [ID_W-1:0] id);
        int pos;
        int i;
        pos = 0;
        while (pos < store_count && store_key[pos] <= k)
            pos++;
        for (i = store_count; i > pos; i--) begin
            store_key[i] = store_key[i - 1];
            store_id[i]  = store_id[i - 1];
        end
        store_key[pos] = k;
        store_id[pos]  = id;
        store_count++;
    endfunction

    // Keep the candidate if there is room or it beats the worst held key.
    function automatic bit try_insert(input logic signed [KEY_W-1:0] k,
                                      input logic [ID_W-1:0] id);
        int j;
        if (store_count < K) begin
            place_entry(k, id);
            return 1'b1;
        end
        if (!keep_largest) begin
            // Worst is the last entry, which is also the newest of equal keys.
            if (!(k < store_key[K - 1]))
                return 1'b0;
            drop_entry(K - 1);
        end else begin
            // Worst is the newest entry of the leading group of equal smallest keys.
            if (!(k > store_key[0]))
                return 1'b0;
            j = 0;
            while (j + 1 < K && store_key[j + 1] == store_key[0])
                j++;
            drop_entry(j);
        end
        place_entry(k, id);
        return 1'b1;
    endfunction

    // Queue the results caused by one accepted request.
    task automatic predict_request(input logic req, input logic signed [KEY_W-1:0] k,
                                   input logic [ID_W-1:0] id);
        sel_result_t r;
        bit          kept;
        int          i;
        if (req == REQ_INSERT) begin
            kept = try_insert(k, id);
            if (kept)
                n_kept++;
            else
                n_dropped++;
            r = '{kept: kept, valid: 1'b0, key: '0, id: '0, last: 1'b1};
            queue_expected(r);
        end else begin
            n_readouts++;
            if (store_count == 0) begin
                r = '{kept: 1'b0, valid: 1'b0, key: '0, id: '0, last: 1'b1};
                queue_expected(r);
            end else begin
                for (i = 0; i < store_count; i++) begin
                    r = '{kept: 1'b0, valid: 1'b1, key: store_key[i], id: store_id[i],
                          last: (i == store_count - 1)};
                    queue_expected(r);
                end
            end
        end
    endtask

    // Compare one result transfer with the oldest expectation.
    task automatic check_result();
        sel_result_t want;
        n_results++;
        if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", out_key, 32'd0);
        end else begin
            want = expected_q.pop_front();
            if (accepted !== want.kept)
                report_mismatch("accepted", 32'(accepted), 32'(want.kept));
            if (entry_valid !== want.valid)
                report_mismatch("entry_valid", 32'(entry_valid), 32'(want.valid));
            if (out_key !== want.key)
                report_mismatch("out_key", out_key, want.key);
            if (out_id !== want.id)
                report_mismatch("out_id", out_id, want.id);
            if (last !== want.last)
                report_mismatch("last", 32'(last), 32'(want.last));
        end
    endtask

    // Results go first: a result at an edge never belongs to a request taken at that edge.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            store_count  = 0;
            keep_largest = 1'b0;
            expected_q.delete();
            pending <= 0;
        end else begin
            if (result_strobe)
                check_result();
            if (cfg_we)
                keep_largest = cfg_wdata;
            if (start && !busy)
                predict_request(req_type, key, cand_id);
            pending <= expected_q.size();
        end
    end

endmodule

@@ tb/k_smallest_selector_tb.sv @@
// Testbench top for the k-smallest selector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module k_smallest_selector_tb;
    import kss_pkg::*;

    localparam int K          = 16;
    localparam int MAX_GAP    = 18;
    localparam int PHASE_LEN  = 24;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic                    cfg_wdata = 1'b0;
    logic                    start     = 1'b0;
    logic                    req_type  = REQ_INSERT;
    logic signed [KEY_W-1:0] key       = '0;
    logic [ID_W-1:0]         cand_id   = '0;

    logic                    busy;
    logic                    result_strobe;
    logic                    accepted;
    logic                    entry_valid;
    logic signed [KEY_W-1:0] out_key;
    logic [ID_W-1:0]         out_id;
    logic                    last;

    int fail_count;
    int pending;
    int results_seen;
    int inserts_kept;
    int inserts_dropped;
    int readouts_seen;

    // 0: no gaps, 1: any gap up to the maximum, 2: at least half the requests back to back.
    int idle_style = 0;

    k_smallest_selector #(
        .K(K)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .key          (key),
        .cand_id      (cand_id),
        .result_strobe(result_strobe),
        .accepted     (accepted),
        .entry_valid  (entry_valid),
        .out_key      (out_key),
        .out_id       (out_id),
        .last         (last)
    );

    k_smallest_selector_checker #(
        .K(K)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .key            (key),
        .cand_id        (cand_id),
        .result_strobe  (result_strobe),
        .accepted       (accepted),
        .entry_valid    (entry_valid),
        .out_key        (out_key),
        .out_id         (out_id),
        .last           (last),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .inserts_kept   (inserts_kept),
        .inserts_dropped(inserts_dropped),
        .readouts_seen  (readouts_seen)
    );

    // Free-running clock, 10 ns period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #2ms;
        $display("k_smallest_selector_tb NOT OK");
        $finish;
    end

    // Present one request after a random gap and hold it until the block takes the transfer.
    task automatic issue_request(input req_t req, input logic signed [KEY_W-1:0] k,
                                 input logic [ID_W-1:0] id);
        int gap;
        case (idle_style)
            0:       gap = 0;
            1:       gap = $urandom_range(0, MAX_GAP);
            default: gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, MAX_GAP);
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= req;
        key      <= k;
        cand_id  <= id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop sending and wait until every expected result has arrived and the block is idle.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    // Change the selection mode while the block is idle.
    task automatic write_mode(input logic largest);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= largest;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Keys: a narrow band in four of ten draws so ties and evictions are frequent, plus extremes and noise.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                v = int'($urandom_range(0, 40)) - 20;
                return v;
            end
            4:       return KEY_MIN + $urandom_range(0, 1);
            5:       return KEY_MAX - $urandom_range(0, 1);
            6, 7:    return $urandom;
            default: begin
                v = int'($urandom_range(0, 2000)) - 1000;
                return v <<< 16;
            end
        endcase
    endfunction

    // Stimulus and verdict.
    initial
    begin
        int phase;
        int n;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty store, extremes, ties, a full store and a mode change.
        idle_style = 2;
        issue_request(REQ_READOUT, 0, 0);
        issue_request(REQ_INSERT, KEY_MIN, 32'hFFFF_FFFF);
        issue_request(REQ_INSERT, KEY_MAX, 32'h0000_0000);
        issue_request(REQ_INSERT, 5, 32'hA1);
        issue_request(REQ_READOUT, 0, 0);
        issue_request(REQ_INSERT, 5, 32'hA2);
        issue_request(REQ_INSERT, KEY_MIN, 32'h1);
        issue_request(REQ_INSERT, KEY_MAX, 32'h2);
        issue_request(REQ_INSERT, 0, 32'h3);
        issue_request(REQ_INSERT, -1, 32'h4);
        issue_request(REQ_INSERT, 1, 32'h5);
        issue_request(REQ_INSERT, 5, 32'hA3);
        issue_request(REQ_INSERT, 100, 32'h6);
        issue_request(REQ_INSERT, -100, 32'h7);
        issue_request(REQ_INSERT, 7, 32'h8);
        issue_request(REQ_INSERT, KEY_MAX, 32'h9);
        issue_request(REQ_INSERT, 32'sh0001_0000, 32'hA);
        issue_request(REQ_INSERT, KEY_MAX - 1, 32'hB);
        // Store is full: an equal worst key is refused, a better one evicts the newest max.
        issue_request(REQ_INSERT, KEY_MAX, 32'hC);
        issue_request(REQ_INSERT, 6, 32'hD);
        issue_request(REQ_READOUT, 0, 0);
        // Largest mode with entries held: the most negative key cannot beat itself.
        write_mode(1'b1);
        issue_request(REQ_INSERT, KEY_MIN, 32'hE);
        issue_request(REQ_INSERT, 2, 32'hF);
        issue_request(REQ_READOUT, 0, 0);

        // Random part: four phases alternating the mode and the idle pattern.
        for (phase = 0; phase < 4; phase++) begin
            write_mode(phase[0]);
            case (phase)
                0:       idle_style = 1;
                1:       idle_style = 0;
                2:       idle_style = 2;
                default: idle_style = 1;
            endcase
            for (n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(0, 5) == 0)
                    issue_request(REQ_READOUT, $urandom, $urandom);
                else
                    issue_request(REQ_INSERT, pick_key(), $urandom);
            end
        end
        issue_request(REQ_READOUT, 0, 0);

        // Drain, then allow a full insert walk for anything stray.
        wait_for_results();
        repeat (2 * K + 8) @(posedge clk);

        $display("Run covered %0d readouts and %0d inserts (%0d kept, %0d refused),",
                 readouts_seen, inserts_kept + inserts_dropped, inserts_kept,
                 inserts_dropped);
        $display("with %0d result transfers checked across both selection modes.",
                 results_seen);
        if (fail_count == 0)
            $display("k_smallest_selector_tb OK");
        else
            $display("k_smallest_selector_tb NOT OK");
        $finish;
    end

endmodule
